// ===== sv/mtp_pkg.sv =====
// Shared types and constants for the MT19937 generator.
// Used by mtp_word_unit and mersenne_twister_prng; depends on nothing else.
package mtp_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int ADDR_W       = 10;
    localparam int WORD_W       = 32;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [WORD_W-1:0] word_t;

    localparam addr_t LAST_ADDR   = addr_t'(STATE_WORDS - 1);
    localparam addr_t WORDS_ADDR  = addr_t'(STATE_WORDS);
    localparam addr_t FAR_SPLIT   = addr_t'(STATE_WORDS - TWIST_OFFSET);
    localparam addr_t FAR_FORWARD = addr_t'(TWIST_OFFSET);

    localparam word_t SEED_MULT  = 32'h41c6_4e6d;
    localparam word_t SEED_ADD   = 32'h0000_6073;
    localparam word_t MATRIX_A   = 32'h9908_b0df;
    localparam word_t TEMPER_B   = 32'h9d2c_5680;
    localparam word_t TEMPER_C   = 32'hefc6_0000;
    localparam word_t UPPER_BIT  = 32'h8000_0000;
    localparam word_t LOWER_BITS = 32'h7fff_ffff;

    // Request kinds carried in tuser
    localparam logic REQ_SEED = 1'b0;
    localparam logic REQ_NEXT = 1'b1;

    // Operation codes of the shared word unit
    typedef logic [1:0] unit_op_t;
    localparam unit_op_t OP_SEED   = 2'd0;
    localparam unit_op_t OP_TWIST  = 2'd1;
    localparam unit_op_t OP_TEMPER = 2'd2;

    // Operand bundle handed to the word unit
    typedef struct packed {
        unit_op_t op;
        word_t    a;
        word_t    b;
        word_t    c;
    } unit_req_t;

endpackage

// ===== sv/mersenne_twister_prng.sv =====
// MT19937 generator top level: 624-word state store, sequencer, stream ports.
// Depends on mtp_pkg and mtp_word_unit.
//
// A beat with tuser 0 seeds the store from tdata; a beat with tuser 1 asks for the
// next tempered word, which leaves on the master side as one beat. A seed is the
// accept, then one store word a cycle through the shared multiply-add. A next
// request is the accept, a store read and the temper into the output register;
// when the store is used up it first runs the twist, one word a cycle through the
// shared word unit on the two-read-port store (a priming read, one step per word and
// a final write), once every 624 outputs. The block takes a new beat only between
// requests; while an earlier result still waits on the master side, a next request
// holds in its temper step and the slave side stays not ready. Before the first
// seed every output is zero, with no clearing pass needed after reset.
module mersenne_twister_prng
    import mtp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seed_value
    input  logic [0:0]  s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] random_value
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEED   = 3'd1;
    localparam logic [2:0] ST_PRIME  = 3'd2;
    localparam logic [2:0] ST_TWIST  = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    logic [2:0] state_reg, state_next;
    addr_t      cnt_reg, cnt_next;
    addr_t      read_index_reg, read_index_next;
    logic       seeded_reg, seeded_next;
    logic       wr_pend_reg, wr_pend_next;
    addr_t      wr_idx_reg, wr_idx_next;
    word_t      cur_reg, cur_next;
    logic       m_tvalid_reg, m_tvalid_next;
    word_t      m_tdata_reg, m_tdata_next;

    // store ports
    word_t      mem [0:STATE_WORDS-1];
    logic       we;
    addr_t      waddr;
    word_t      wdata;
    logic       re;
    addr_t      raddr_a;
    addr_t      raddr_b;
    word_t      rdata_a;
    word_t      rdata_b;

    unit_req_t  ureq;
    word_t      ures;
    logic       accept;
    logic       out_free;

    mtp_word_unit u_unit (
        .req    (ureq),
        .result (ures)
    );

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // store: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        read_index_next = read_index_reg;
        seeded_next     = seeded_reg;
        wr_pend_next    = wr_pend_reg;
        wr_idx_next     = wr_idx_reg;
        cur_next        = cur_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        we              = 1'b0;
        waddr           = cnt_reg;
        wdata           = cur_reg;
        re              = 1'b0;
        raddr_a         = '0;
        raddr_b         = '0;
        ureq.op         = OP_SEED;
        ureq.a          = cur_reg;
        ureq.b          = rdata_a;
        ureq.c          = rdata_b;

        // drop the output beat once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser[0] == REQ_SEED) begin
                        cur_next   = s_tdata;
                        cnt_next   = '0;
                        state_next = ST_SEED;
                    end else if (seeded_reg && (read_index_reg >= WORDS_ADDR)) begin
                        state_next = ST_PRIME;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_SEED: begin
                // write one word, advance the recurrence
                we       = 1'b1;
                waddr    = cnt_reg;
                wdata    = cur_reg;
                ureq.op  = OP_SEED;
                cur_next = ures;
                cnt_next = cnt_reg + addr_t'(1);
                if (cnt_reg == LAST_ADDR) begin
                    seeded_next     = 1'b1;
                    read_index_next = WORDS_ADDR;
                    state_next      = ST_IDLE;
                end
            end
            ST_PRIME: begin
                // fetch word 0 ahead of the twist
                re           = 1'b1;
                raddr_a      = '0;
                raddr_b      = '0;
                cnt_next     = '0;
                wr_pend_next = 1'b0;
                state_next   = ST_TWIST;
            end
            ST_TWIST: begin
                // write the word whose operands have arrived
                ureq.op = OP_TWIST;
                ureq.a  = cur_reg;
                we      = wr_pend_reg;
                waddr   = wr_idx_reg;
                wdata   = ures;
                cur_next = rdata_a;
                // issue reads for the next word
                if (cnt_reg != WORDS_ADDR) begin
                    re      = 1'b1;
                    raddr_a = (cnt_reg == LAST_ADDR) ? addr_t'(0) : cnt_reg + addr_t'(1);
                    raddr_b = (cnt_reg < FAR_SPLIT) ? cnt_reg + FAR_FORWARD
                                                    : cnt_reg - FAR_SPLIT;
                    wr_pend_next = 1'b1;
                    wr_idx_next  = cnt_reg;
                    cnt_next     = cnt_reg + addr_t'(1);
                end else begin
                    wr_pend_next    = 1'b0;
                    read_index_next = '0;
                    state_next      = ST_READ;
                end
            end
            ST_READ: begin
                re         = 1'b1;
                raddr_a    = read_index_reg;
                raddr_b    = read_index_reg;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                // temper into the output register when it is free
                ureq.op = OP_TEMPER;
                ureq.a  = rdata_a;
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    m_tdata_next    = seeded_reg ? ures : '0;
                    read_index_next = read_index_reg + addr_t'(1);
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            read_index_reg <= WORDS_ADDR;
            seeded_reg     <= 1'b0;
            wr_pend_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            read_index_reg <= read_index_next;
            seeded_reg     <= seeded_next;
            wr_pend_reg    <= wr_pend_next;
            m_tvalid_reg   <= m_tvalid_next;
            cnt_reg        <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        wr_idx_reg  <= wr_idx_next;
        cur_reg     <= cur_next;
        m_tdata_reg <= m_tdata_next;
    end

    // a twist only runs on a seeded store
    a_twist_seeded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TWIST) |-> seeded_reg)
        else $error("twist running on an unseeded store");

    // the read index never passes the used-up mark while seeded
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (seeded_reg && state_reg == ST_IDLE) |-> (read_index_reg <= WORDS_ADDR))
        else $error("read index beyond the store");

    // a finished twist restarts reading at word 0
    a_twist_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TWIST && cnt_reg == WORDS_ADDR) |=> (read_index_reg == '0))
        else $error("read index not reset after twist");

    // hold a stalled output beat unchanged until it is taken
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output beat changed while stalled");

endmodule

// ===== sv/mtp_word_unit.sv =====
// Shared word unit: seed recurrence step, twist of one word, tempering.
// Depends on mtp_pkg.
module mtp_word_unit
    import mtp_pkg::*;
(
    input  unit_req_t req,
    output word_t     result
);

    word_t y;
    word_t t1;
    word_t t2;
    word_t t3;
    word_t prod;

    always_comb begin
        prod   = req.a * SEED_MULT;
        y      = (req.a & UPPER_BIT) | (req.b & LOWER_BITS);
        t1     = req.a ^ (req.a >> 11);
        t2     = t1 ^ ((t1 << 7) & TEMPER_B);
        t3     = t2 ^ ((t2 << 15) & TEMPER_C);
        // select the operation
        case (req.op)
            OP_SEED: begin
                result = prod + SEED_ADD;
            end
            OP_TWIST: begin
                result = req.c ^ (y >> 1) ^ (y[0] ? MATRIX_A : '0);
            end
            OP_TEMPER: begin
                result = t3 ^ (t3 >> 18);
            end
            default: begin
                result = '0;
            end
        endcase
    end

endmodule
